[sv/lpks_pkg.sv]
package lpks_pkg;

	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_DEL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic done;
		logic success;
	} res_t;

endpackage

[sv/lpks_ram.sv]
module lpks_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/lpks_seq.sv]
module lpks_seq #(
	parameter int HOME_BITS   = 8,
	parameter int HOME_SPREAD = 2,
	parameter int PROBE_LIMIT = 256,
	parameter int SKW         = 32,
	localparam int TABLE_BITS = HOME_BITS + HOME_SPREAD,
	localparam int CW         = $clog2(PROBE_LIMIT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  ready,
	input  lpks_pkg::cmd_t        cmd,
	input  logic [SKW-1:0]        key,
	input  logic                  out_take,
	output lpks_pkg::res_t        res,
	output logic                  ram_we,
	output logic [TABLE_BITS-1:0] ram_waddr,
	output logic [SKW:0]          ram_wdata,
	output logic                  ram_re,
	output logic [TABLE_BITS-1:0] ram_raddr,
	input  logic [SKW:0]          ram_rdata
);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_PROBE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                st_q;
	logic [TABLE_BITS-1:0] clr_q;
	logic [TABLE_BITS-1:0] addr_q;
	logic [CW-1:0]         cnt_q;
	lpks_pkg::cmd_t        cmd_q;
	logic [SKW-1:0]        key_q;
	logic                  ok_q;
	logic                  rv_s1;
	logic                  last_s1;
	logic [TABLE_BITS-1:0] addr_s1;

	logic [HOME_BITS+SKW-1:0] key_ext;
	logic [TABLE_BITS-1:0]    home;
	logic                     slot_vld;
	logic                     hit;
	logic                     decide;
	logic                     decide_ok;
	logic                     probe_we;
	logic                     probe_wvld;
	logic                     issue;

	assign key_ext = (HOME_BITS + SKW)'(key);
	assign home    = TABLE_BITS'(key_ext[HOME_BITS-1:0]) << HOME_SPREAD;

	assign slot_vld = ram_rdata[SKW];
	assign hit      = slot_vld && (ram_rdata[SKW-1:0] == key_q);

	always_comb begin
		decide     = 1'b0;
		decide_ok  = 1'b0;
		probe_we   = 1'b0;
		probe_wvld = 1'b0;
		if (st_q == ST_PROBE && rv_s1) begin
			unique case (cmd_q)
				lpks_pkg::CMD_ADD: begin
					if (!slot_vld) begin
						decide     = 1'b1;
						decide_ok  = 1'b1;
						probe_we   = 1'b1;
						probe_wvld = 1'b1;
					end else if (hit) begin
						decide = 1'b1;
					end
				end
				lpks_pkg::CMD_DEL: begin
					if (hit) begin
						decide    = 1'b1;
						decide_ok = 1'b1;
						probe_we  = 1'b1;
					end
				end
				default: begin
					decide = 1'b1;
				end
			endcase
			if (!decide && last_s1) begin
				decide = 1'b1;
			end
		end
	end

	assign issue = (st_q == ST_PROBE) && !decide && (cnt_q != CW'(PROBE_LIMIT));

	assign ram_re    = issue;
	assign ram_raddr = addr_q;
	assign ram_we    = (st_q == ST_CLEAR) || probe_we;
	assign ram_waddr = (st_q == ST_CLEAR) ? clr_q : addr_s1;
	assign ram_wdata = (st_q == ST_CLEAR) ? '0
		: (probe_wvld ? {1'b1, key_q} : '0);

	assign ready       = (st_q == ST_IDLE);
	assign res.done    = (st_q == ST_FINISH);
	assign res.success = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				last_s1 <= (cnt_q == CW'(PROBE_LIMIT - 1));
				addr_s1 <= addr_q;
				addr_q  <= addr_q + 1'b1;
				cnt_q   <= cnt_q + 1'b1;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						key_q  <= key;
						addr_q <= home;
						cnt_q  <= '0;
						st_q   <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (decide) begin
						ok_q <= decide_ok;
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_take) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(PROBE_LIMIT))
		else $error("probe count beyond limit");

	a_start_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(start && st_q == ST_IDLE) |=> (st_q == ST_PROBE))
		else $error("accepted transaction did not start probing");

	a_probe_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && st_q != ST_CLEAR) |-> (st_q == ST_PROBE && rv_s1 && decide_ok))
		else $error("table write outside a successful probe");

	a_no_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FINISH) |-> (!ram_re && !ram_we))
		else $error("table access while result waits");
`endif

endmodule

[sv/linear_probe_key_set.sv]
// Set of keys in an open-addressing table of 2^(HOME_BITS+HOME_SPREAD) slots
// (1024 by default), each slot holding a valid bit and a key in one RAM word.
// A key's home slot is its low HOME_BITS bits shifted left by HOME_SPREAD;
// probing walks up one slot per cycle, wrapping, for at most PROBE_LIMIT
// slots. Add (tuser 0) stores the key in the first empty slot, failing on a
// duplicate found before it or on a full window; delete (tuser 1) clears the
// first valid slot holding the key anywhere in the window. Slots are read
// through the single RAM read port that the probe sequencer uses once per
// cycle; the block takes one transaction at a time. After reset a clearing
// pass over all 2^(HOME_BITS+HOME_SPREAD) slots runs before the first
// transaction is accepted.
module linear_probe_key_set #(
	parameter int HOME_BITS   = 8,
	parameter int HOME_SPREAD = 2,
	parameter int PROBE_LIMIT = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic        s_tuser,   // [0] command: 0 add, 1 delete
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] success
);

	localparam int SKW        = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int TABLE_BITS = HOME_BITS + HOME_SPREAD;

	lpks_pkg::res_t        res;
	logic                  take;
	logic                  m_tvalid_q;
	logic                  success_q;
	logic                  ram_we;
	logic [TABLE_BITS-1:0] ram_waddr;
	logic [SKW:0]          ram_wdata;
	logic                  ram_re;
	logic [TABLE_BITS-1:0] ram_raddr;
	logic [SKW:0]          ram_rdata;

	assign take = !m_tvalid_q || m_tready;

	lpks_seq #(
		.HOME_BITS   (HOME_BITS),
		.HOME_SPREAD (HOME_SPREAD),
		.PROBE_LIMIT (PROBE_LIMIT),
		.SKW         (SKW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && s_tready),
		.ready     (s_tready),
		.cmd       (lpks_pkg::cmd_t'(s_tuser)),
		.key       (s_tdata[SKW-1:0]),
		.out_take  (take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	lpks_ram #(
		.WIDTH (SKW + 1),
		.DEPTH (1 << TABLE_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.done && take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done && take) begin
			success_q <= res.success;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, success_q};

endmodule
